### hw/rtl/plt_pkg.sv
// ----------------------------------------------------------------------------
// plt_pkg
// shared widths, register codes, reset values and unit status for the
// piecewise linear temperature linearizer
// ----------------------------------------------------------------------------
package plt_pkg;

	// default number of calibration points
	localparam int unsigned POINTS_DEF = 7;

	// field and lane widths
	localparam int unsigned LANE_W     = 16;
	localparam int unsigned SAMPLE_W   = 16;
	localparam int unsigned GAIN_W     = 16;
	localparam int unsigned TEMP_W     = 16;
	localparam int unsigned STATUS_W   = 2;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 64;

	// datapath widths
	localparam int unsigned MUL_AW     = 17;  // signed multiplicand
	localparam int unsigned MUL_BW     = 16;  // unsigned multiplier, one bit per step
	localparam int unsigned PROD_W     = MUL_AW + MUL_BW;
	localparam int unsigned V_W        = 17;  // millivolts, signed
	localparam int unsigned VOLT_SHIFT = 15;
	localparam int unsigned NUM_W      = 34;
	localparam int unsigned DIVD_W     = 35;
	localparam int unsigned DIVS_W     = 17;
	localparam int unsigned QUO_W      = 18;

	// result kinds
	typedef enum logic [STATUS_W-1:0] {
		ST_INTERP   = 2'd0,
		ST_CLAMP_HI = 2'd1,
		ST_CLAMP_LO = 2'd2,
		ST_NO_SEG   = 2'd3
	} status_t;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DIVIDER_GAIN     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VOLT_POINTS_LOW  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VOLT_POINTS_HIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_POINTS_LOW  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_POINTS_HIGH = 3'd4;

	// register reset values
	localparam logic [GAIN_W-1:0]     GAIN_RST      = 16'd4096;
	localparam logic [CFG_DATA_W-1:0] VOLT_LO_RST   = 64'd723404984062972308;
	localparam logic [CFG_DATA_W-1:0] VOLT_HI_RST   = 64'd3715229812530;
	localparam logic [CFG_DATA_W-1:0] TEMP_LO_RST   = 64'd16888670402641920;
	localparam logic [CFG_DATA_W-1:0] TEMP_HI_RST   = 64'd515402629200;

	// result constants
	localparam logic signed [TEMP_W-1:0] NO_SEG_TEMP = -16'sd999;
	localparam logic signed [TEMP_W-1:0] TEMP_MAX    = 16'sh7fff;
	localparam logic signed [TEMP_W-1:0] TEMP_MIN    = 16'sh8000;

	// status of a serial arithmetic unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

### hw/rtl/plt_smul.sv
// ----------------------------------------------------------------------------
// plt_smul
// bit-serial signed by unsigned multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module plt_smul #(
	parameter int unsigned AW = plt_pkg::MUL_AW,
	parameter int unsigned BW = plt_pkg::MUL_BW
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [AW-1:0]      a,
	input  logic        [BW-1:0]      b,
	output plt_pkg::unit_stat_t       stat,
	output logic signed [AW+BW-1:0]   prod
);
	import plt_pkg::*;

	localparam int unsigned CW = $clog2(BW + 1);

	logic signed [AW-1:0]   a_q;
	logic signed [AW:0]     hi_q;
	logic        [BW-1:0]   lo_q;
	logic        [CW-1:0]   cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic signed [AW:0]     addend;
	logic signed [AW:0]     sum;
	logic        [AW+BW:0]  full;

	// partial product high half, low bits shift out through lo_q
	assign addend = lo_q[0] ? (AW+1)'(a_q) : '0;
	assign sum    = hi_q + addend;
	assign full   = {hi_q, lo_q};
	assign prod   = signed'(full[AW+BW-1:0]);

	assign stat.busy = busy_q;
	assign stat.done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				a_q    <= a;
				hi_q   <= '0;
				lo_q   <= b;
				cnt_q  <= CW'(BW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				hi_q  <= sum >>> 1;
				lo_q  <= {sum[0], lo_q[BW-1:1]};
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

### hw/rtl/plt_div.sv
// ----------------------------------------------------------------------------
// plt_div
// radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module plt_div #(
	parameter int unsigned NW = plt_pkg::DIVD_W,
	parameter int unsigned DW = plt_pkg::DIVS_W,
	parameter int unsigned QW = plt_pkg::QUO_W
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [NW-1:0]        dividend,
	input  logic [DW-1:0]        divisor,
	output plt_pkg::unit_stat_t  stat,
	output logic [QW-1:0]        quotient
);
	import plt_pkg::*;

	localparam int unsigned CW = $clog2(QW + 1);

	logic [DW-1:0] rem_q;
	logic [QW-1:0] quo_q;
	logic [DW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;

	// dividend bits leave quo_q at the top into the remainder, quotient bits enter at the bottom
	assign trial = {rem_q, quo_q[QW-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				// upper part is below the divisor since the quotient fits QW bits
				rem_q  <= DW'(dividend >> QW);
				quo_q  <= dividend[QW-1:0];
				dvs_q  <= divisor;
				cnt_q  <= CW'(QW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
				quo_q <= {quo_q[QW-2:0], ge};
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

### hw/rtl/piecewise_linear_temp_linearizer.sv
// ----------------------------------------------------------------------------
// piecewise_linear_temp_linearizer
// Converts a signed ADC sample (0.125 mV per step) to millivolts through the
// divider gain, v = (sample * divider_gain) >>> 15, then maps v through a
// table of POINTS descending voltage breakpoints to a temperature in whole
// degrees. v at or above the first point clamps to the first temperature
// (tuser 1), at or below the last point to the last temperature (tuser 2);
// otherwise the first segment that holds v is interpolated, rounded to
// nearest with ties away from zero and saturated to 16 bits (tuser 0). When
// no segment holds v the table is not descending and the result is -999 with
// tuser 3. One item is worked at a time: s_tready is high only while no item
// is in progress, while a finished result may still wait in the output
// register. Every item takes a 16-step pass of bit-serial multiplier a for v;
// one that is not clamped then searches the segments in order, and one that
// is interpolated takes a second 16-step pass of multiplier a, with b in step,
// and the 18-step serial divider. The user must write registers through
// cfg_we / cfg_index / cfg_wdata only while idle; not enforced by the block.
// ----------------------------------------------------------------------------
module piecewise_linear_temp_linearizer #(
	parameter int unsigned POINTS = plt_pkg::POINTS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// input stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [plt_pkg::SAMPLE_W-1:0]       s_tdata,    // [15:0] adc_sample
	// result stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [plt_pkg::TEMP_W-1:0]         m_tdata,    // [15:0] temperature
	output logic [plt_pkg::STATUS_W-1:0]       m_tuser,    // [1:0] status
	// register write port
	input  logic                               cfg_we,
	input  logic [plt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [plt_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import plt_pkg::*;

	localparam int unsigned IW = $clog2(POINTS);
	localparam logic [IW-1:0] SEG_LAST = IW'(POINTS - 2);
	localparam logic [QUO_W-1:0] Q_POS_MAX = QUO_W'(32767);
	localparam logic [QUO_W-1:0] Q_NEG_MAX = QUO_W'(32768);

	typedef enum logic [3:0] {
		S_IDLE,
		S_MULV,
		S_CHK,
		S_SRCH,
		S_MULN,
		S_MAG,
		S_DIVST,
		S_DIV,
		S_DONE
	} state_t;

	// configuration registers
	logic [GAIN_W-1:0]      gain_q;
	logic [CFG_DATA_W-1:0]  volt_lo_q;
	logic [CFG_DATA_W-1:0]  volt_hi_q;
	logic [CFG_DATA_W-1:0]  temp_lo_q;
	logic [CFG_DATA_W-1:0]  temp_hi_q;

	// breakpoint lanes unpacked from the registers
	logic [LANE_W-1:0]      volt_lane [POINTS];
	logic [LANE_W-1:0]      temp_lane [POINTS];

	// sequencer state and working registers
	state_t                 state_q;
	logic [LANE_W-1:0]      vsh_q [POINTS];
	logic [LANE_W-1:0]      tsh_q [POINTS];
	logic [IW-1:0]          seg_q;
	logic signed [V_W-1:0]  v_q;
	logic [LANE_W-1:0]      den_q;
	logic signed [NUM_W-1:0] num_q;
	logic [NUM_W-1:0]       mag_q;
	logic                   neg_q;
	logic signed [TEMP_W-1:0] res_temp_q;
	status_t                res_status_q;
	logic                   m_tvalid_q;
	logic [TEMP_W-1:0]      m_tdata_q;
	status_t                m_tuser_q;

	// datapath
	logic                   accept;
	logic [LANE_W-1:0]      va;
	logic [LANE_W-1:0]      vb;
	logic [LANE_W-1:0]      ta;
	logic [LANE_W-1:0]      tb;
	logic signed [V_W-1:0]  va_s;
	logic signed [V_W-1:0]  vb_s;
	logic signed [V_W-1:0]  first_s;
	logic signed [V_W-1:0]  last_s;
	logic                   seg_match;
	logic [LANE_W-1:0]      den;
	logic signed [V_W-1:0]  dv_full;
	logic signed [MUL_AW-1:0] dt;

	logic                   mul_a_start;
	logic signed [MUL_AW-1:0] mul_a_a;
	logic [MUL_BW-1:0]      mul_a_b;
	unit_stat_t             mul_a_st;
	logic signed [PROD_W-1:0] mul_a_p;
	logic                   mul_b_start;
	unit_stat_t             mul_b_st;
	logic signed [PROD_W-1:0] mul_b_p;

	logic signed [NUM_W-1:0] num_sum;
	logic [NUM_W-1:0]       mag_c;
	logic                   div_start;
	logic [DIVD_W-1:0]      dividend;
	logic [DIVS_W-1:0]      divisor;
	unit_stat_t             div_st;
	logic [QUO_W-1:0]       quo;
	logic signed [TEMP_W-1:0] t_sat;

	// lane k lives in the low register for k < 4, else in the high one
	for (genvar k = 0; k < POINTS; k++) begin : g_lane
		assign volt_lane[k] = (k < 4) ? volt_lo_q[LANE_W*(k%4) +: LANE_W]
		                              : volt_hi_q[LANE_W*(k%4) +: LANE_W];
		assign temp_lane[k] = (k < 4) ? temp_lo_q[LANE_W*(k%4) +: LANE_W]
		                              : temp_hi_q[LANE_W*(k%4) +: LANE_W];
	end

	// register write port, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q    <= GAIN_RST;
			volt_lo_q <= VOLT_LO_RST;
			volt_hi_q <= VOLT_HI_RST;
			temp_lo_q <= TEMP_LO_RST;
			temp_hi_q <= TEMP_HI_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DIVIDER_GAIN:     gain_q    <= cfg_wdata[GAIN_W-1:0];
				REG_VOLT_POINTS_LOW:  volt_lo_q <= cfg_wdata;
				REG_VOLT_POINTS_HIGH: volt_hi_q <= cfg_wdata;
				REG_TEMP_POINTS_LOW:  temp_lo_q <= cfg_wdata;
				REG_TEMP_POINTS_HIGH: temp_hi_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	// current segment sits at the head of the lane shifters
	assign va      = vsh_q[0];
	assign vb      = vsh_q[1];
	assign ta      = tsh_q[0];
	assign tb      = tsh_q[1];
	assign va_s    = signed'({1'b0, va});
	assign vb_s    = signed'({1'b0, vb});
	assign first_s = signed'({1'b0, volt_lane[0]});
	assign last_s  = signed'({1'b0, volt_lane[POINTS-1]});

	assign seg_match = (v_q <= va_s) && (v_q > vb_s);
	assign den       = va - vb;
	assign dv_full   = va_s - v_q;
	assign dt        = signed'({tb[LANE_W-1], tb}) - signed'({ta[LANE_W-1], ta});

	// multiplier a: sample * gain first, then ta * den
	// multiplier b: dt * (va - v), in step with the second pass of a
	assign mul_a_start = accept || ((state_q == S_SRCH) && seg_match);
	assign mul_a_a     = (state_q == S_IDLE) ? MUL_AW'(signed'(s_tdata))
	                                         : MUL_AW'(signed'(ta));
	assign mul_a_b     = (state_q == S_IDLE) ? gain_q : den;
	assign mul_b_start = (state_q == S_SRCH) && seg_match;

	plt_smul #(
		.AW (MUL_AW),
		.BW (MUL_BW)
	) u_mul_a (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_a_start),
		.a      (mul_a_a),
		.b      (mul_a_b),
		.stat   (mul_a_st),
		.prod   (mul_a_p)
	);

	plt_smul #(
		.AW (MUL_AW),
		.BW (MUL_BW)
	) u_mul_b (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_b_start),
		.a      (dt),
		.b      (dv_full[MUL_BW-1:0]),
		.stat   (mul_b_st),
		.prod   (mul_b_p)
	);

	// numerator ta*den + dt*(va - v), then rounding by (2|num| + den) / (2 den)
	assign num_sum   = NUM_W'(mul_a_p) + NUM_W'(mul_b_p);
	assign mag_c     = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
	assign div_start = (state_q == S_DIVST);
	assign dividend  = {mag_q, 1'b0} + DIVD_W'(den_q);
	assign divisor   = {den_q, 1'b0};

	plt_div #(
		.NW (DIVD_W),
		.DW (DIVS_W),
		.QW (QUO_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.stat     (div_st),
		.quotient (quo)
	);

	// sign and saturate the rounded magnitude
	always_comb begin
		if (!neg_q) begin
			t_sat = (quo > Q_POS_MAX) ? TEMP_MAX : signed'(quo[TEMP_W-1:0]);
		end else begin
			t_sat = (quo > Q_NEG_MAX) ? TEMP_MIN : signed'(-quo[TEMP_W-1:0]);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
			seg_q      <= '0;
		end else begin
			// result taken by the sink, a new one is loaded in S_DONE instead
			if (m_tvalid_q && m_tready && (state_q != S_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						for (int k = 0; k < POINTS; k++) begin
							vsh_q[k] <= volt_lane[k];
							tsh_q[k] <= temp_lane[k];
						end
						state_q <= S_MULV;
					end
				end
				S_MULV: begin
					if (mul_a_st.done) begin
						v_q     <= mul_a_p[VOLT_SHIFT+V_W-1:VOLT_SHIFT];
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					seg_q <= '0;
					if (v_q >= first_s) begin
						res_temp_q   <= signed'(temp_lane[0]);
						res_status_q <= ST_CLAMP_HI;
						state_q      <= S_DONE;
					end else if (v_q <= last_s) begin
						res_temp_q   <= signed'(temp_lane[POINTS-1]);
						res_status_q <= ST_CLAMP_LO;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_SRCH;
					end
				end
				S_SRCH: begin
					if (seg_match) begin
						den_q   <= den;
						state_q <= S_MULN;
					end else if (seg_q == SEG_LAST) begin
						// no segment holds v: table not descending
						res_temp_q   <= NO_SEG_TEMP;
						res_status_q <= ST_NO_SEG;
						state_q      <= S_DONE;
					end else begin
						for (int k = 0; k < POINTS - 1; k++) begin
							vsh_q[k] <= vsh_q[k+1];
							tsh_q[k] <= tsh_q[k+1];
						end
						seg_q <= seg_q + IW'(1);
					end
				end
				S_MULN: begin
					if (mul_a_st.done) begin
						num_q   <= num_sum;
						state_q <= S_MAG;
					end
				end
				S_MAG: begin
					neg_q   <= num_q[NUM_W-1];
					mag_q   <= mag_c;
					state_q <= S_DIVST;
				end
				S_DIVST: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_st.done) begin
						res_temp_q   <= t_sat;
						res_status_q <= ST_INTERP;
						state_q      <= S_DONE;
					end
				end
				S_DONE: begin
					// output register free or being emptied this cycle
					if (!m_tvalid_q || m_tready) begin
						m_tdata_q  <= res_temp_q;
						m_tuser_q  <= res_status_q;
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// a pass of multiplier a never starts on top of a running one
	a_mul_a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mul_a_start |-> !mul_a_st.busy)
		else $error("multiplier a started while busy");

	// both numerator products finish in the same cycle
	a_mul_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MULN) |-> (mul_a_st.done == mul_b_st.done))
		else $error("numerator multipliers out of step");

	// divider is started only when idle
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_st.busy)
		else $error("divider started while busy");

	// search stays within the table
	a_seg_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRCH) |-> (seg_q <= SEG_LAST))
		else $error("segment search ran past the last segment");

endmodule
